// ----- rtl/ppu_pkg.sv -----
// ----------------------------------------------------------------------------
// ppu_pkg
// Types, constants and state codes shared by the particle pool update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ppu_pkg;

    localparam int POOL_SIZE = 256;
    localparam int SLOT_W    = $clog2(POOL_SIZE);
    localparam int LINK_W    = SLOT_W + 1;      // one more bit for the "none" link
    localparam int COUNT_W   = 9;
    localparam int OUT_SLOT_W = 8;

    localparam logic [7:0]        FULL_OPACITY = 8'd255;
    localparam logic [LINK_W-1:0] NO_SLOT      = LINK_W'(POOL_SIZE);

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_SPAWN = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
        logic [14:0]        life_ticks;
        logic [7:0]         fade_step;
    } req_t;

    typedef struct packed {
        logic                  accepted;
        logic [OUT_SLOT_W-1:0] slot;
        logic [COUNT_W-1:0]    live_count;
        logic [COUNT_W-1:0]    expired_count;
    } rsp_t;

    // one particle as held in the data RAM
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [7:0]  opacity;
        logic [7:0]  fade;
        logic [15:0] life;
    } slot_data_t;

    localparam int PART_W = $bits(slot_data_t);

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [LINK_W-1:0] data;
    } link_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAWN,
        ST_PROC,
        ST_RELINK,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/ppu_ram.sv -----
// ----------------------------------------------------------------------------
// ppu_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/ppu_link_mem.sv -----
// ----------------------------------------------------------------------------
// ppu_link_mem
// Next-slot links of the active and free lists. Entries never written read
// as slot+1 (last slot reads as none), tracked by one valid bit per entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_link_mem
    import ppu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire link_wr_t          wr,
    input  wire logic [SLOT_W-1:0] raddr,
    output logic      [LINK_W-1:0] rdata
);

    logic [LINK_W-1:0] mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] written_reg;
    logic [LINK_W-1:0] mem_q_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] raddr_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        mem_q_reg <= mem[raddr];
        raddr_reg <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                written_reg[wr.addr] <= 1'b1;
            end
            hit_reg <= written_reg[raddr];
        end
    end

    assign rdata = hit_reg ? mem_q_reg : ({1'b0, raddr_reg} + LINK_W'(1));

endmodule

`default_nettype wire

// ----- rtl/ppu_step.sv -----
// ----------------------------------------------------------------------------
// ppu_step
// One tick of one particle: fade, age, expiry test and motion update.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_step
    import ppu_pkg::*;
(
    input  wire slot_data_t cur,
    output slot_data_t      upd,
    output logic            dead
);

    logic        borrow;
    logic [15:0] life_dec;

    always_comb
    begin
        borrow   = cur.fade > cur.opacity;
        life_dec = cur.life - 16'd1;
        dead     = borrow || (life_dec == 16'd0);

        upd         = cur;
        upd.opacity = cur.opacity - cur.fade;
        // lifetime is left alone when the opacity wraps
        upd.life    = borrow ? cur.life : life_dec;
        upd.px      = cur.px + cur.vx;
        upd.py      = cur.py + cur.vy;
        upd.pz      = cur.pz + cur.vz;
        upd.vx      = cur.vx + cur.ax;
        upd.vy      = cur.vy + cur.ay;
        upd.vz      = cur.vz + cur.az;
    end

endmodule

`default_nettype wire

// ----- rtl/particle_pool_update_unit.sv -----
// ----------------------------------------------------------------------------
// particle_pool_update_unit
// Particle pool with active and free lists: spawn pops a free slot, tick
// walks the active list updating, fading and retiring particles.
// ----------------------------------------------------------------------------
// Sequence: spawn IDLE, SPAWN, FINISH; refused spawn IDLE, FINISH; tick IDLE,
//   PROC per live particle plus RELINK per expiring one with a predecessor, FINISH.
// Throughput: one item in work at a time; the next item is taken the cycle after
//   a result is posted, and its own result waits until the held one drains.
// Reset: control registers clear at once; link store reads as its initial
//   chain through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module particle_pool_update_unit
    import ppu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    state_t             state_reg,       state_next;
    logic [LINK_W-1:0]  active_head_reg, active_head_next;
    logic [LINK_W-1:0]  free_head_reg,   free_head_next;
    logic [COUNT_W-1:0] live_total_reg,  live_total_next;
    logic [SLOT_W-1:0]  cur_reg,         cur_next;
    logic [SLOT_W-1:0]  prev_reg,        prev_next;
    logic               has_prev_reg,    has_prev_next;
    logic [LINK_W-1:0]  next_reg,        next_next;
    logic [LINK_W-1:0]  visits_reg,      visits_next;
    logic [COUNT_W-1:0] expired_reg,     expired_next;
    logic               acc_reg,         acc_next;
    logic [OUT_SLOT_W-1:0] slot_reg,     slot_next;
    logic               rsp_valid_reg,   rsp_valid_next;
    rsp_t               rsp_reg,         rsp_next;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    slot_data_t        ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    logic [PART_W-1:0] ram_rdata;
    slot_data_t        cur_part;
    slot_data_t        upd_part;
    logic              dead;

    link_wr_t          link_wr;
    logic [SLOT_W-1:0] link_raddr;
    logic [LINK_W-1:0] link_rdata;

    logic [LINK_W-1:0] visits_inc;
    logic              more;
    logic [LINK_W-1:0] follow;

    ppu_ram #(
        .WIDTH (PART_W),
        .DEPTH (POOL_SIZE)
    ) u_data_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ppu_link_mem u_link_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (link_wr),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign cur_part = slot_data_t'(ram_rdata);

    ppu_step u_step (
        .cur  (cur_part),
        .upd  (upd_part),
        .dead (dead)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            active_head_reg <= NO_SLOT;
            free_head_reg   <= '0;
            live_total_reg  <= '0;
            has_prev_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            active_head_reg <= active_head_next;
            free_head_reg   <= free_head_next;
            live_total_reg  <= live_total_next;
            has_prev_reg    <= has_prev_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        next_reg    <= next_next;
        visits_reg  <= visits_next;
        expired_reg <= expired_next;
        acc_reg     <= acc_next;
        slot_reg    <= slot_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        active_head_next = active_head_reg;
        free_head_next   = free_head_reg;
        live_total_next  = live_total_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        has_prev_next    = has_prev_reg;
        next_next        = next_reg;
        visits_next      = visits_reg;
        expired_next     = expired_reg;
        acc_next         = acc_reg;
        slot_next        = slot_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;

        req_ready  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg;
        ram_wdata  = upd_part;
        ram_raddr  = cur_reg;
        link_wr    = '{en: 1'b0, addr: cur_reg, data: free_head_reg};
        link_raddr = cur_reg;

        visits_inc = visits_reg + LINK_W'(1);
        follow     = link_rdata;
        more       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    expired_next = '0;
                    slot_next    = '0;
                    if (req.mode == MODE_SPAWN)
                    begin
                        if (free_head_reg < NO_SLOT)
                        begin
                            // payload goes straight into the free slot
                            ram_we            = 1'b1;
                            ram_waddr         = free_head_reg[SLOT_W-1:0];
                            ram_wdata.px      = req.pos_x;
                            ram_wdata.py      = req.pos_y;
                            ram_wdata.pz      = req.pos_z;
                            ram_wdata.vx      = req.vel_x;
                            ram_wdata.vy      = req.vel_y;
                            ram_wdata.vz      = req.vel_z;
                            ram_wdata.ax      = req.acc_x;
                            ram_wdata.ay      = req.acc_y;
                            ram_wdata.az      = req.acc_z;
                            ram_wdata.opacity = FULL_OPACITY;
                            ram_wdata.fade    = req.fade_step;
                            ram_wdata.life    = {1'b0, req.life_ticks};
                            link_raddr        = free_head_reg[SLOT_W-1:0];
                            state_next        = ST_SPAWN;
                        end
                        else
                        begin
                            acc_next   = 1'b0;
                            state_next = ST_FINISH;
                        end
                    end
                    else
                    begin
                        acc_next      = 1'b1;
                        visits_next   = '0;
                        has_prev_next = 1'b0;
                        if (active_head_reg < NO_SLOT)
                        begin
                            cur_next   = active_head_reg[SLOT_W-1:0];
                            ram_raddr  = active_head_reg[SLOT_W-1:0];
                            link_raddr = active_head_reg[SLOT_W-1:0];
                            state_next = ST_PROC;
                        end
                        else
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end

            ST_SPAWN:
            begin
                link_wr          = '{en: 1'b1, addr: free_head_reg[SLOT_W-1:0],
                                     data: active_head_reg};
                active_head_next = free_head_reg;
                free_head_next   = link_rdata;
                live_total_next  = live_total_reg + COUNT_W'(1);
                acc_next         = 1'b1;
                slot_next        = OUT_SLOT_W'(free_head_reg[SLOT_W-1:0]);
                state_next       = ST_FINISH;
            end

            ST_PROC:
            begin
                ram_we      = 1'b1;
                visits_next = visits_inc;
                follow      = link_rdata;
                more        = 1'b1;
                if (dead)
                begin
                    link_wr        = '{en: 1'b1, addr: cur_reg, data: free_head_reg};
                    free_head_next = {1'b0, cur_reg};
                    expired_next   = expired_reg + COUNT_W'(1);
                    if (live_total_reg != '0)
                    begin
                        live_total_next = live_total_reg - COUNT_W'(1);
                    end
                    if (has_prev_reg)
                    begin
                        // predecessor link is patched next cycle
                        next_next  = link_rdata;
                        state_next = ST_RELINK;
                        more       = 1'b0;
                    end
                    else
                    begin
                        active_head_next = link_rdata;
                    end
                end
                else
                begin
                    prev_next     = cur_reg;
                    has_prev_next = 1'b1;
                end
                if (more)
                begin
                    if (visits_inc < NO_SLOT && follow < NO_SLOT)
                    begin
                        cur_next   = follow[SLOT_W-1:0];
                        ram_raddr  = follow[SLOT_W-1:0];
                        link_raddr = follow[SLOT_W-1:0];
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_RELINK:
            begin
                link_wr = '{en: 1'b1, addr: prev_reg, data: next_reg};
                if (visits_reg < NO_SLOT && next_reg < NO_SLOT)
                begin
                    cur_next   = next_reg[SLOT_W-1:0];
                    ram_raddr  = next_reg[SLOT_W-1:0];
                    link_raddr = next_reg[SLOT_W-1:0];
                    state_next = ST_PROC;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.accepted      = acc_reg;
                    rsp_next.slot          = slot_reg;
                    rsp_next.live_count    = live_total_reg;
                    rsp_next.expired_count = expired_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- tb/sv/particle_pool_update_unit_tb.sv -----
// ----------------------------------------------------------------------------
// particle_pool_update_unit_tb
// Self-checking bench: a short table of spawns and ticks, then random items
// with pool-filling bursts, run under several idle and stall mixes. A
// software copy of both lists predicts every result, and each response is
// compared field by field in order with that prediction (pinned rows: table value).
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module particle_pool_update_unit_tb
    import ppu_pkg::*;
();

    localparam int IDLE_LIMIT   = 20000;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 470;
    localparam int BURST_SPAWNS = POOL_SIZE + 6;
    localparam int BURST_TICKS  = 20;

    typedef struct {
        req_t item;
        bit   pinned;
        rsp_t want;
    } table_row_t;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // typed expectation that rides along with a table item
    logic pin_on    = 1'b0;
    rsp_t pin_rsp   = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;

    rsp_t pending_rsp[$];
    int   mismatches = 0;
    int   idle_cycles = 0;

    // shadow of the particle pool
    bit [31:0] pool_pos [POOL_SIZE][3];
    bit [31:0] pool_vel [POOL_SIZE][3];
    bit [31:0] pool_acc [POOL_SIZE][3];
    bit [7:0]  pool_opacity [POOL_SIZE];
    bit [7:0]  pool_fade [POOL_SIZE];
    bit [15:0] pool_life [POOL_SIZE];
    int        pool_next [POOL_SIZE];
    int        active_first;
    int        free_first;
    int        live_now;

    particle_pool_update_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function void pool_reset();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_next[i] = i + 1;
        end
        active_first = POOL_SIZE;
        free_first   = 0;
        live_now     = 0;
    endfunction

    function rsp_t pool_step(req_t r);
        rsp_t o;
        int   cur;
        int   prev;
        int   nxt;
        int   freed;
        bit   has_prev;
        bit   dead;
        bit [7:0] old_op;
        o = '0;
        if (r.mode == MODE_SPAWN)
        begin
            o.live_count = live_now[COUNT_W-1:0];
            if (free_first >= POOL_SIZE)
                return o;               // pool full: nothing changes
            cur = free_first;
            free_first = pool_next[cur];
            pool_next[cur] = active_first;
            active_first = cur;
            pool_pos[cur][0] = r.pos_x;
            pool_pos[cur][1] = r.pos_y;
            pool_pos[cur][2] = r.pos_z;
            pool_vel[cur][0] = r.vel_x;
            pool_vel[cur][1] = r.vel_y;
            pool_vel[cur][2] = r.vel_z;
            pool_acc[cur][0] = r.acc_x;
            pool_acc[cur][1] = r.acc_y;
            pool_acc[cur][2] = r.acc_z;
            pool_life[cur]    = {1'b0, r.life_ticks};
            pool_fade[cur]    = r.fade_step;
            pool_opacity[cur] = FULL_OPACITY;
            live_now++;
            o.accepted   = 1'b1;
            o.slot       = cur[OUT_SLOT_W-1:0];
            o.live_count = live_now[COUNT_W-1:0];
            return o;
        end
        cur = active_first;
        prev = 0;
        has_prev = 1'b0;
        freed = 0;
        for (int visits = 0; visits < POOL_SIZE && cur < POOL_SIZE; visits++)
        begin
            old_op = pool_opacity[cur];
            nxt = pool_next[cur];
            pool_opacity[cur] = old_op - pool_fade[cur];
            if (pool_fade[cur] > old_op)
                dead = 1'b1;            // opacity borrow, life left alone
            else
            begin
                pool_life[cur] = pool_life[cur] - 16'd1;
                dead = (pool_life[cur] == 16'd0);
            end
            if (dead)
            begin
                if (has_prev)
                    pool_next[prev] = nxt;
                else
                    active_first = nxt;
                pool_next[cur] = free_first;
                free_first = cur;
                freed++;
                if (live_now > 0)
                    live_now--;
            end
            else
            begin
                for (int a = 0; a < 3; a++)
                begin
                    pool_pos[cur][a] = pool_pos[cur][a] + pool_vel[cur][a];
                    pool_vel[cur][a] = pool_vel[cur][a] + pool_acc[cur][a];
                end
                prev = cur;
                has_prev = 1'b1;
            end
            cur = nxt;
        end
        o.accepted      = 1'b1;
        o.live_count    = live_now[COUNT_W-1:0];
        o.expired_count = freed[COUNT_W-1:0];
        return o;
    endfunction

    function void note_mismatch(string what, rsp_t want, rsp_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t %s: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     $realtime, what, want.accepted, want.slot, want.live_count,
                     want.expired_count, got.accepted, got.slot, got.live_count,
                     got.expired_count);
    endfunction

    // result checking, prediction at request accept, watchdog
    always @(posedge clk)
    begin : monitor
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                    note_mismatch("unexpected result", '0, rsp);
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.accepted != want.accepted || rsp.slot != want.slot ||
                        rsp.live_count != want.live_count ||
                        rsp.expired_count != want.expired_count)
                        note_mismatch("result mismatch", want, rsp);
                end
            end
            if (req_valid && req_ready)
            begin
                want = pool_step(req);
                if (pin_on)
                    want = pin_rsp;
                pending_rsp.push_back(want);
            end
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("particle_pool_update_unit_tb: FAIL");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function req_t dir_spawn(bit [31:0] p0, bit [31:0] p1, bit [31:0] p2,
                             bit [31:0] v0, bit [31:0] v1, bit [31:0] v2,
                             bit [31:0] a0, bit [31:0] a1, bit [31:0] a2,
                             bit [14:0] life, bit [7:0] fade);
        req_t r;
        r.mode  = MODE_SPAWN;
        r.pos_x = p0;
        r.pos_y = p1;
        r.pos_z = p2;
        r.vel_x = v0;
        r.vel_y = v1;
        r.vel_z = v2;
        r.acc_x = a0;
        r.acc_y = a1;
        r.acc_z = a2;
        r.life_ticks = life;
        r.fade_step  = fade;
        return r;
    endfunction

    function req_t make_spawn(bit [14:0] life, bit [7:0] fade);
        return dir_spawn($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, life, fade);
    endfunction

    // tick with a random, ignored payload
    function req_t tick_item();
        req_t r;
        r = make_spawn(15'($urandom_range(0, 32767)), 8'($urandom_range(0, 255)));
        r.mode = MODE_TICK;
        return r;
    endfunction

    function req_t random_item();
        int k;
        if ($urandom_range(0, 99) < 55)
            return tick_item();
        k = $urandom_range(0, 15);
        // fade 0 only with short life, so no particle stays for good
        if (k == 0)
            return make_spawn(15'($urandom_range(1, 40)), 8'd0);
        else if (k < 3)
            return make_spawn(15'($urandom_range(0, 32767)), 8'($urandom_range(1, 8)));
        else if (k < 5)
            return make_spawn(15'($urandom_range(0, 32767)), 8'($urandom_range(1, 255)));
        return make_spawn(15'($urandom_range(0, 40)), 8'($urandom_range(1, 255)));
    endfunction

    // called at a clock edge; returns at the edge where the item is taken
    task send_item(req_t r, bit pinned, rsp_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        pin_on    <= pinned;
        pin_rsp   <= want;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task hold_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        table_row_t rows[$];
        int send_mix[4];
        int stall_mix[4];
        int n;
        send_mix  = '{0, 58, 0, 23};
        stall_mix = '{0, 0, 58, 23};
        pool_reset();

        // empty pool, then extreme values with a one-tick life
        rows.push_back('{tick_item(), 1'b1, rsp_t'{1'b1, 8'd0, 9'd0, 9'd0}});
        rows.push_back('{dir_spawn(32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                   32'h1, 32'hFFFF_FFFF, 32'h8000_0000,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                   15'd1, 8'd0),
                         1'b1, rsp_t'{1'b1, 8'd0, 9'd1, 9'd0}});
        rows.push_back('{tick_item(), 1'b1, rsp_t'{1'b1, 8'd0, 9'd0, 9'd1}});
        // zero lifetime with full fade: survives one tick, then opacity wraps
        rows.push_back('{dir_spawn(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   32'h7FFF_FFFF, 32'h1, 32'h8000_0000,
                                   32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1,
                                   15'd0, 8'd255),
                         1'b1, rsp_t'{1'b1, 8'd0, 9'd1, 9'd0}});
        rows.push_back('{tick_item(), 1'b1, rsp_t'{1'b1, 8'd0, 9'd1, 9'd0}});
        rows.push_back('{tick_item(), 1'b1, rsp_t'{1'b1, 8'd0, 9'd0, 9'd1}});
        // four live at once: long life with fade 1, zero fade, fade 128, fade 200
        rows.push_back('{dir_spawn(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   15'h7FFF, 8'd1),
                         1'b1, rsp_t'{1'b1, 8'd0, 9'd1, 9'd0}});
        rows.push_back('{make_spawn(15'd3, 8'd0), 1'b1, rsp_t'{1'b1, 8'd1, 9'd2, 9'd0}});
        rows.push_back('{make_spawn(15'd2, 8'd128), 1'b1, rsp_t'{1'b1, 8'd2, 9'd3, 9'd0}});
        rows.push_back('{make_spawn(15'd5, 8'd200), 1'b1, rsp_t'{1'b1, 8'd3, 9'd4, 9'd0}});
        for (int i = 0; i < 4; i++)
            rows.push_back('{tick_item(), 1'b0, '0});
        rows.push_back('{dir_spawn(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                   32'h0, 32'h0, 32'h0, 15'd4, 8'd0), 1'b0, '0});
        rows.push_back('{dir_spawn(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   15'h7FFF, 8'd255), 1'b0, '0});
        for (int i = 0; i < 5; i++)
            rows.push_back('{tick_item(), 1'b0, '0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].item, rows[i].pinned, rows[i].want);

        for (int ph = 0; ph < 4; ph++)
        begin
            hold_until_drained();
            send_idle_pct = send_mix[ph];
            stall_pct     = stall_mix[ph];
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ((ph == 0 || ph == 2) && n == 100)
                begin
                    // fill the pool past full, then let it thin out
                    for (int k = 0; k < BURST_SPAWNS; k++)
                        send_item(make_spawn(15'($urandom_range(0, 32767)),
                                             8'($urandom_range(16, 255))), 1'b0, '0);
                    for (int k = 0; k < BURST_TICKS; k++)
                        send_item(tick_item(), 1'b0, '0);
                    n += BURST_SPAWNS + BURST_TICKS;
                    hold_until_drained();
                end
                else
                begin
                    send_item(random_item(), 1'b0, '0);
                    n++;
                    if ($urandom_range(0, 199) == 0)
                        hold_until_drained();
                end
            end
        end

        req_valid <= 1'b0;
        pin_on    <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("particle_pool_update_unit_tb: PASS");
        else
            $display("particle_pool_update_unit_tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ppu_pkg.sv
rtl/ppu_ram.sv
rtl/ppu_link_mem.sv
rtl/ppu_step.sv
rtl/particle_pool_update_unit.sv
tb/sv/particle_pool_update_unit_tb.sv
